// ===== hdl/itoar_pkg.sv =====
// Shared types, constants and digit-to-ASCII mapping for the radix converter.
// No dependencies; used by every module of the block.
package itoar_pkg;

    localparam int STEP_BITS = 8;
    localparam int RADIX_W   = 6;
    localparam int PAD_W     = 7;
    localparam int CHAR_W    = 7;
    localparam int COUNT_W   = 7;
    localparam int DIGIT_W   = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_ALPHA_OFS = 7'h37;

    typedef struct packed {
        logic load;
        logic step;
        logic digit_done;
        logic emit_init;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic radix_ok;
        logic quo_zero;
        logic full;
        logic pos_zero;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        if (d < DEC_DIGITS) begin
            return ASCII_ZERO + CHAR_W'(d);
        end else begin
            return ASCII_ALPHA_OFS + CHAR_W'(d);
        end
    endfunction

endpackage

// ===== hdl/itoar_ctrl.sv =====
// Sequencer for the radix converter: load, per-digit division passes, emission.
// Depends on itoar_pkg for the command and status structs.
module itoar_ctrl #(
    parameter int ITERS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  itoar_pkg::t_sts   i_sts,
    output itoar_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;
    localparam int ITW = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam logic [ITW-1:0] CNT_LAST = ITW'(ITERS - 1);

    logic [1:0]     r_state, n_state;
    logic [ITW-1:0] r_cnt, n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_sts.radix_ok) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0 && (i_sts.quo_zero || i_sts.full)) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_RD;
                end else begin
                    o_cmd.step = 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        o_cmd.digit_done = 1'b1;
                        n_cnt            = '0;
                    end else begin
                        n_cnt = r_cnt + ITW'(1);
                    end
                end
            end
            S_RD: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = i_sts.pos_zero ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hdl/itoar_dp.sv =====
// Datapath for the radix converter: multi-bit restoring divider, digit store,
// emission pointer and output register. Depends on itoar_pkg.
module itoar_dp #(
    parameter int MAX_DIGITS = 64,
    parameter int VALUE_BITS = 64,
    parameter int ITERS      = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic [itoar_pkg::RADIX_W-1:0]     i_radix,
    input  logic [itoar_pkg::PAD_W-1:0]       i_pad_width,
    input  logic                              i_stall,
    input  itoar_pkg::t_cmd                   i_cmd,
    output itoar_pkg::t_sts                   o_sts,
    output logic                              o_valid,
    output logic [itoar_pkg::CHAR_W-1:0]      o_ascii_char,
    output logic [itoar_pkg::COUNT_W-1:0]     o_digit_count,
    output logic                              o_last
);

    localparam int QW = ITERS * itoar_pkg::STEP_BITS;
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int DW = itoar_pkg::DIGIT_W;

    logic [QW-1:0]                   r_quo;
    logic [DW-1:0]                   r_rem;
    logic [itoar_pkg::RADIX_W-1:0]   r_radix;
    logic [CW-1:0]                   r_pad;
    logic [CW-1:0]                   r_ndig;
    logic [CW-1:0]                   r_total;
    logic [CW-1:0]                   r_count;
    logic [AW-1:0]                   r_pos;
    logic [DW-1:0]                   r_rd;
    logic                            r_valid;
    logic [itoar_pkg::CHAR_W-1:0]    r_char;
    logic                            r_last;
    logic [DW-1:0]                   mem [MAX_DIGITS];

    logic [QW-1:0]  div_quo;
    logic [DW-1:0]  div_rem;
    logic [DW:0]    trial;
    logic [CW-1:0]  total;
    logic [CW-1:0]  pad_sat;
    logic [DW-1:0]  digit;

    // STEP_BITS quotient bits per cycle, remainder stays below the radix
    always_comb begin
        div_quo = r_quo;
        div_rem = r_rem;
        trial   = '0;
        for (int b = 0; b < itoar_pkg::STEP_BITS; b++) begin
            trial   = {div_rem, div_quo[QW-1]};
            div_quo = {div_quo[QW-2:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                trial      = trial - {1'b0, r_radix};
                div_quo[0] = 1'b1;
            end
            div_rem = trial[DW-1:0];
        end
    end

    always_comb begin
        total = (r_ndig > r_pad) ? r_ndig : r_pad;
        if (total == '0) begin
            total = CW'(1);
        end
    end

    assign pad_sat = (i_pad_width > itoar_pkg::PAD_W'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                                  : CW'(i_pad_width);
    // positions above the collected digits are padding zeros
    assign digit = (CW'(r_pos) >= r_ndig) ? '0 : r_rd;

    assign o_sts.radix_ok = (i_radix >= itoar_pkg::RADIX_MIN) &&
                            (i_radix <= itoar_pkg::RADIX_MAX);
    assign o_sts.quo_zero = (r_quo == '0);
    assign o_sts.full     = (r_ndig == CW'(MAX_DIGITS));
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.digit_done) begin
            mem[r_ndig[AW-1:0]] <= div_rem;
        end
        r_rd <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= QW'(i_value);
            r_rem   <= '0;
            r_radix <= i_radix;
            r_pad   <= pad_sat;
            r_ndig  <= '0;
        end else if (i_cmd.step) begin
            r_quo <= div_quo;
            if (i_cmd.digit_done) begin
                r_rem  <= '0;
                r_ndig <= r_ndig + CW'(1);
            end else begin
                r_rem <= div_rem;
            end
        end
        if (i_cmd.emit_init) begin
            r_total <= total;
            r_pos   <= AW'(total - CW'(1));
        end else if (i_cmd.put) begin
            r_pos <= r_pos - AW'(1);
        end
        if (i_cmd.put) begin
            r_char  <= itoar_pkg::to_ascii(digit);
            r_count <= r_total;
            r_last  <= (r_pos == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_ascii_char  = r_char;
    assign o_digit_count = itoar_pkg::COUNT_W'(r_count);
    assign o_last        = r_last;

endmodule

// ===== hdl/integer_to_ascii_radix_core.sv =====
// Integer to ASCII conversion in radix 2..36, most significant digit first.
// Sequence: load, one division pass per digit for D digits, then a read state and a put state
// per character; the put state waits while the output register is held by i_stall.
// Throughput: one item at a time, set by the divider's 8-bits-per-cycle digit loop.
// Reset: synchronous active-low; clears the sequencer and output valid, digit store is not cleared.
// Depends on itoar_pkg, itoar_ctrl and itoar_dp.
module integer_to_ascii_radix_core #(
    parameter int MAX_DIGITS = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic [itoar_pkg::RADIX_W-1:0]     i_radix,
    input  logic [itoar_pkg::PAD_W-1:0]       i_pad_width,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [itoar_pkg::CHAR_W-1:0]      o_ascii_char,
    output logic [itoar_pkg::COUNT_W-1:0]     o_digit_count,
    output logic                              o_last
);

    localparam int ITERS = (VALUE_BITS + itoar_pkg::STEP_BITS - 1) / itoar_pkg::STEP_BITS;

    itoar_pkg::t_cmd cmd;
    itoar_pkg::t_sts sts;

    itoar_ctrl #(
        .ITERS (ITERS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itoar_dp #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS),
        .ITERS      (ITERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_pad_width   (i_pad_width),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_ascii_char  (o_ascii_char),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

endmodule

// ===== test/integer_to_ascii_radix_core_test.sv =====
// Testbench for integer_to_ascii_radix_core: directed and random conversions checked
// character by character against an in-bench digit predictor, with random idling on both sides.
// Depends on itoar_pkg and integer_to_ascii_radix_core.
`timescale 1ns / 100ps

module integer_to_ascii_radix_core_test;

    localparam int VALUE_W    = 64;
    localparam int DIGITS_MAX = 64;
    localparam int DRAIN_CYCLES = 800;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 345;

    typedef struct packed {
        logic [itoar_pkg::CHAR_W-1:0]  ch;
        logic [itoar_pkg::COUNT_W-1:0] count;
        logic                          last;
    } t_char;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [VALUE_W-1:0]              i_value;
    logic [itoar_pkg::RADIX_W-1:0]   i_radix;
    logic [itoar_pkg::PAD_W-1:0]     i_pad_width;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [itoar_pkg::CHAR_W-1:0]    o_ascii_char;
    logic [itoar_pkg::COUNT_W-1:0]   o_digit_count;
    logic                            o_last;

    t_char pending_chars[$];
    int    mismatches     = 0;
    int    items_sent     = 0;
    int    items_ignored  = 0;
    int    chars_checked  = 0;
    bit    tx_quiet       = 1'b0;
    bit    rx_quiet       = 1'b0;
    int    stall_left     = 0;

    integer_to_ascii_radix_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_pad_width   (i_pad_width),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ascii_char  (o_ascii_char),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Digit string of one conversion, most significant first, queued as expected characters.
    function automatic void predict_digits(logic [VALUE_W-1:0] value,
                                           logic [itoar_pkg::RADIX_W-1:0] radix,
                                           logic [itoar_pkg::PAD_W-1:0] pad);
        logic [itoar_pkg::DIGIT_W-1:0] digits [DIGITS_MAX];
        logic [VALUE_W-1:0]            quo;
        logic [itoar_pkg::DIGIT_W-1:0] d;
        int                            n;
        int                            min_len;
        t_char                         c;
        if (radix < itoar_pkg::RADIX_MIN || radix > itoar_pkg::RADIX_MAX) begin
            items_ignored++;
            return;
        end
        min_len = (pad > DIGITS_MAX) ? DIGITS_MAX : int'(pad);
        quo = value;
        n = 0;
        while (quo != 0 && n < DIGITS_MAX) begin
            digits[n] = itoar_pkg::DIGIT_W'(quo % VALUE_W'(radix));
            quo = quo / VALUE_W'(radix);
            n++;
        end
        while (n < min_len) begin
            digits[n] = '0;
            n++;
        end
        if (n == 0) begin
            digits[0] = '0;
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            d = digits[n - 1 - k];
            c.ch    = (d < 10) ? itoar_pkg::CHAR_W'(8'h30 + d)
                               : itoar_pkg::CHAR_W'(8'h41 + d - 10);
            c.count = itoar_pkg::COUNT_W'(n);
            c.last  = (k == n - 1);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic send_item(logic [VALUE_W-1:0] value, logic [itoar_pkg::RADIX_W-1:0] radix,
                             logic [itoar_pkg::PAD_W-1:0] pad);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= value;
        i_radix     <= radix;
        i_pad_width <= pad;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
        predict_digits(value, radix, pad);
    endtask

    task automatic wait_drained();
        int spin;
        spin = 0;
        while (pending_chars.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        if (pending_chars.size() != 0) begin
            $error("drain stuck: %0d characters still expected", pending_chars.size());
            mismatches++;
        end
    endtask

    // Result side: stall draws after each transfer, occasional stalls while idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (o_valid === 1'b1 && !i_stall) begin
            stall_left = draw_wait(rx_quiet);
            i_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0) begin
                i_stall <= 1'b0;
            end
        end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11);
            i_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $error("unexpected character transfer: char %h count %0d last %b",
                       o_ascii_char, o_digit_count, o_last);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (o_ascii_char !== want.ch) begin
                    $error("ascii_char: expected %h, got %h", want.ch, o_ascii_char);
                    mismatches++;
                end
                if (o_digit_count !== want.count) begin
                    $error("digit_count: expected %0d, got %0d", want.count, o_digit_count);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_value     <= '0;
        i_radix     <= '0;
        i_pad_width <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_zero_and_padding();
        send_item(64'd0, 6'd10, 7'd0);
        send_item(64'd0, 6'd2, 7'd1);
        send_item(64'd0, 6'd16, 7'd64);
        send_item(64'd255, 6'd16, 7'd8);
        send_item(64'd12345, 6'd10, 7'd127);
        send_item(64'd7, 6'd8, 7'd65);
        send_item(64'd1, 6'd2, 7'd0);
    endtask

    task automatic test_extreme_values();
        send_item({VALUE_W{1'b1}}, 6'd2, 7'd0);
        send_item({VALUE_W{1'b1}}, 6'd36, 7'd0);
        send_item({VALUE_W{1'b1}}, 6'd10, 7'd0);
        send_item({VALUE_W{1'b1}}, 6'd16, 7'd64);
        send_item(64'd35, 6'd36, 7'd0);
        send_item(64'hDEAD_BEEF_0123_4567, 6'd16, 7'd0);
        send_item(64'h8000_0000_0000_0000, 6'd3, 7'd0);
        send_item(64'd1295, 6'd36, 7'd3);
    endtask

    task automatic test_bad_radix();
        send_item(64'd42, 6'd0, 7'd5);
        send_item(64'd42, 6'd1, 7'd0);
        send_item(64'd42, 6'd37, 7'd0);
        send_item({VALUE_W{1'b1}}, 6'd63, 7'd127);
        send_item(64'd9, 6'd10, 7'd0);
    endtask

    task automatic test_back_to_back();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int k = 0; k < 12; k++) begin
            send_item(VALUE_W'($urandom), 6'($urandom_range(2, 36)), 7'($urandom_range(0, 6)));
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_item(64'd1000, 6'd7, 7'd2);
        send_item(64'd99, 6'd2, 7'd0);
        i_valid <= 1'b0;
        wait_drained();
        send_item(64'd31, 6'd32, 7'd0);
    endtask

    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return v;
            1: return v >> $urandom_range(0, 63);
            2: return VALUE_W'($urandom_range(0, 1000));
            3: return {VALUE_W{1'b1}};
            4: return '0;
            default: return v >> $urandom_range(32, 63);
        endcase
    endfunction

    function automatic logic [itoar_pkg::RADIX_W-1:0] draw_radix();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? itoar_pkg::RADIX_W'($urandom_range(0, 1))
                                        : itoar_pkg::RADIX_W'($urandom_range(37, 63));
        end
        case ($urandom_range(0, 7))
            0: return 6'd2;
            1: return 6'd10;
            2: return 6'd16;
            3: return 6'd36;
            default: return itoar_pkg::RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    task automatic test_random_items();
        int                            converted;
        logic [itoar_pkg::RADIX_W-1:0] radix;
        logic [itoar_pkg::PAD_W-1:0]   pad;
        converted = 0;
        while (converted < RANDOM_ITEMS) begin
            if (converted % 50 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            radix = draw_radix();
            pad = ($urandom_range(0, 9) == 0) ? itoar_pkg::PAD_W'($urandom_range(0, 127))
                                              : itoar_pkg::PAD_W'($urandom_range(0, 16));
            send_item(draw_value(), radix, pad);
            if (radix >= itoar_pkg::RADIX_MIN && radix <= itoar_pkg::RADIX_MAX) begin
                converted++;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        test_reset();
        test_zero_and_padding();
        test_extreme_values();
        test_bad_radix();
        test_back_to_back();
        test_drain_pause();
        test_random_items();
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d characters never arrived", pending_chars.size());
            mismatches++;
        end
        $display("Run covered %0d conversion requests (%0d with unsupported radix),",
                 items_sent, items_ignored);
        $display("and %0d output characters compared; %0d mismatches.",
                 chars_checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
